// ===== hw/rtl/ptf_pkg.sv =====
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared widths, register reset values, opcodes, register indexes, forecast
// codes and the control/status structs of the pressure trend forecaster.
// ----------------------------------------------------------------------------
package ptf_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int OP_W   = 2;
    localparam int PRES_W = 17;
    localparam int TEMP_W = 15;
    localparam int SECS_W = 32;
    localparam int IDX_W  = 6;
    localparam int TRND_W = 18;
    localparam int CODE_W = 3;
    localparam int THR_W  = 14;
    localparam int ENTRY_W = PRES_W + TEMP_W + SECS_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TREND_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND   = 3'd4;

    localparam logic [CODE_W-1:0] FC_CLEAR_IMPROVING  = 3'd0;
    localparam logic [CODE_W-1:0] FC_CLEAR_STABLE     = 3'd1;
    localparam logic [CODE_W-1:0] FC_PARTLY_CLOUDY    = 3'd2;
    localparam logic [CODE_W-1:0] FC_CLOUDY_CLEARING  = 3'd3;
    localparam logic [CODE_W-1:0] FC_POSSIBLE_RAIN    = 3'd4;
    localparam logic [CODE_W-1:0] FC_RAIN_WORSENING   = 3'd5;
    localparam logic [CODE_W-1:0] FC_CLOUDY_IMPROVING = 3'd6;
    localparam logic [CODE_W-1:0] FC_OVERCAST         = 3'd7;

    localparam logic [THR_W-1:0]  TREND_THR_RST  = 14'd100;
    localparam logic [THR_W-1:0]  STRONG_THR_RST = 14'd130;
    localparam logic [SECS_W-1:0] LOOKBACK_RST   = 32'd10800;
    localparam logic [PRES_W-1:0] HIGH_BAND_RST  = 17'd102000;
    localparam logic [PRES_W-1:0] LOW_BAND_RST   = 17'd100000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic push;
        logic scan_start;
        logic scan_run;
        logic rd_issue;
        logic load_query;
        logic load_read;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/ptf_ram.sv =====
// ----------------------------------------------------------------------------
// ptf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ptf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptf_ctrl
// Sequencer: takes items, runs the history scan or entry read and hands
// finished results to the output register.
// ----------------------------------------------------------------------------
module ptf_ctrl
    import ptf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_in_stall,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_QRES,
        S_RD_ISSUE,
        S_RD_RES
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   acc;

    assign acc = i_in_valid && !r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.latch = 1'b1;
                    case (i_opcode)
                        OP_PUSH: o_cmd.push = 1'b1;
                        OP_QUERY: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                        OP_READ: n_state = S_RD_ISSUE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_QRES;
                end
            end
            S_QRES: begin
                if (i_status.out_free) begin
                    o_cmd.load_query = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_RES;
            end
            S_RD_RES: begin
                if (i_status.out_free) begin
                    o_cmd.load_read = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== hw/rtl/ptf_dp.sv =====
// ----------------------------------------------------------------------------
// ptf_dp
// Datapath: configuration registers, history ring with fill count, scan
// counter and window compare, forecast classifier and output register.
// ----------------------------------------------------------------------------
module ptf_dp
    import ptf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [PRES_W-1:0]        i_pressure,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [SECS_W-1:0]        i_now_seconds,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [TRND_W-1:0] o_trend,
    output logic                     o_trend_found,
    output logic [CODE_W-1:0]        o_forecast_code,
    output logic [PRES_W-1:0]        o_read_pressure,
    output logic signed [TEMP_W-1:0] o_read_temperature,
    output logic [SECS_W-1:0]        o_read_time
);

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = (CW > IDX_W) ? CW : IDX_W;
    localparam int SW = PW + 2;
    localparam int CMP_W = TRND_W + 1;

    // configuration
    logic [THR_W-1:0]  r_trend_thr, r_strong_thr;
    logic [SECS_W-1:0] r_lookback;
    logic [PRES_W-1:0] r_high_band, r_low_band;

    // ring bookkeeping
    logic [PW-1:0] r_wp;
    logic [CW-1:0] r_count;

    // latched item
    logic [PRES_W-1:0] r_press;
    logic [SECS_W-1:0] r_now;
    logic [IDX_W-1:0]  r_idx;

    // scan state
    logic [CW-1:0]            r_age;
    logic                     r_chk;
    logic                     r_found;
    logic signed [TRND_W-1:0] r_trend;

    // output register
    logic                     r_out_valid;
    logic signed [TRND_W-1:0] r_o_trend;
    logic                     r_o_found;
    logic [CODE_W-1:0]        r_o_code;
    logic [PRES_W-1:0]        r_o_press;
    logic signed [TEMP_W-1:0] r_o_temp;
    logic [SECS_W-1:0]        r_o_time;

    logic [ENTRY_W-1:0]       ram_rdata;
    logic [PRES_W-1:0]        rd_press;
    logic signed [TEMP_W-1:0] rd_temp;
    logic [SECS_W-1:0]        rd_time;
    logic                     rd_ok;
    logic [CW-1:0]            rd_age;
    logic [PW-1:0]            raddr;
    logic                     issue;
    logic                     re;
    logic                     hit;
    logic [SECS_W-1:0]        age_secs;
    logic [CODE_W-1:0]        code;
    logic                     out_free;

    // ring slot of age index (0 = oldest); the sum stays below twice the depth
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] wp,
                                              input logic [CW-1:0] cnt,
                                              input logic [CW-1:0] age);
        logic [SW-1:0] s;
        s = SW'(wp) + SW'(HISTORY_DEPTH) - SW'(cnt) + SW'(age);
        if (s >= SW'(HISTORY_DEPTH)) begin
            s = s - SW'(HISTORY_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    ptf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wp),
        .i_wdata ({i_pressure, i_temperature, i_now_seconds}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_press = ram_rdata[ENTRY_W-1 -: PRES_W];
    assign rd_temp  = ram_rdata[SECS_W +: TEMP_W];
    assign rd_time  = ram_rdata[SECS_W-1:0];

    assign rd_ok  = AW'(r_idx) < AW'(r_count);
    assign rd_age = rd_ok ? CW'(r_idx) : '0;
    assign issue  = r_age < r_count;
    assign re     = i_cmd.rd_issue || (i_cmd.scan_run && issue);
    assign raddr  = slot_of(r_wp, r_count, i_cmd.rd_issue ? rd_age : r_age);

    // modulo 2^32 age of the entry under test
    assign age_secs = r_now - rd_time;
    assign hit      = r_chk && (age_secs <= r_lookback);

    assign out_free           = !r_out_valid || !i_out_stall;
    assign o_status.out_free  = out_free;
    assign o_status.scan_done = (r_count < CW'(2)) || hit || (!r_chk && !issue);

    // forecast class from band and trend
    always_comb begin
        logic signed [CMP_W-1:0] tr, thr, steep_thr;
        logic gt, lt, gt_s, lt_s;
        tr        = CMP_W'(r_trend);
        thr       = $signed(CMP_W'(r_trend_thr));
        steep_thr = $signed(CMP_W'(r_strong_thr));
        gt        = tr > thr;
        lt        = tr < -thr;
        gt_s      = tr > steep_thr;
        lt_s      = tr < -steep_thr;
        if (r_press > r_high_band) begin
            code = gt ? FC_CLEAR_IMPROVING : (lt ? FC_PARTLY_CLOUDY : FC_CLEAR_STABLE);
        end else if (r_press > r_low_band) begin
            code = gt ? FC_CLOUDY_CLEARING : (lt ? FC_POSSIBLE_RAIN : FC_PARTLY_CLOUDY);
        end else begin
            code = lt_s ? FC_RAIN_WORSENING : (gt_s ? FC_CLOUDY_IMPROVING : FC_OVERCAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trend_thr  <= TREND_THR_RST;
            r_strong_thr <= STRONG_THR_RST;
            r_lookback   <= LOOKBACK_RST;
            r_high_band  <= HIGH_BAND_RST;
            r_low_band   <= LOW_BAND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TREND_THR:  r_trend_thr  <= i_cfg_data[THR_W-1:0];
                CFG_STRONG_THR: r_strong_thr <= i_cfg_data[THR_W-1:0];
                CFG_LOOKBACK:   r_lookback   <= i_cfg_data[SECS_W-1:0];
                CFG_HIGH_BAND:  r_high_band  <= i_cfg_data[PRES_W-1:0];
                CFG_LOW_BAND:   r_low_band   <= i_cfg_data[PRES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_wp <= (r_wp == PW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (r_count != CW'(HISTORY_DEPTH)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_press <= i_pressure;
            r_now   <= i_now_seconds;
            r_idx   <= i_entry_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age   <= '0;
            r_chk   <= 1'b0;
            r_found <= 1'b0;
            r_trend <= '0;
        end else if (i_cmd.scan_start) begin
            r_age   <= '0;
            r_chk   <= 1'b0;
            r_found <= 1'b0;
            r_trend <= '0;
        end else if (i_cmd.scan_run) begin
            // one read issued while the previous entry is checked
            r_age <= r_age + CW'(issue);
            r_chk <= issue;
            if (hit) begin
                r_found <= 1'b1;
                r_trend <= $signed({1'b0, r_press}) - $signed({1'b0, rd_press});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_query || i_cmd.load_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_o_trend <= r_trend;
            r_o_found <= r_found;
            r_o_code  <= code;
            r_o_press <= '0;
            r_o_temp  <= '0;
            r_o_time  <= '0;
        end else if (i_cmd.load_read) begin
            r_o_trend <= '0;
            r_o_found <= 1'b0;
            r_o_code  <= FC_CLEAR_IMPROVING;
            r_o_press <= rd_ok ? rd_press : '0;
            r_o_temp  <= rd_ok ? rd_temp : '0;
            r_o_time  <= rd_ok ? rd_time : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_trend            = r_o_trend;
    assign o_trend_found      = r_o_found;
    assign o_forecast_code    = r_o_code;
    assign o_read_pressure    = r_o_press;
    assign o_read_temperature = r_o_temp;
    assign o_read_time        = r_o_time;

endmodule

// ===== hw/rtl/pressure_trend_forecaster_top.sv =====
// ----------------------------------------------------------------------------
// pressure_trend_forecaster_top
// Barometric trend over a ring of timestamped samples with an eight-way
// forecast class; controller and datapath joined by command/status structs.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    opcode, pressure, temperature,
//                                                   now_seconds, entry_index
//   out       source     o_out_valid / i_out_stall  trend, trend_found, forecast_code,
//                                                   read_pressure/temperature/time
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// push: next item taken at once; read: issued in S_RD_ISSUE, loaded from S_RD_RES.
// query: one ring entry per cycle through the single RAM read port, stopping at the
// first in-window entry. the next item can be taken in the cycle after a read or
// query result is loaded.
// reset inits pointers, fill count, scan state, out valid, config; ring not cleared.
// a waiting result in the output register does not block the next item; a new
// result waits until the output register is free.
// ----------------------------------------------------------------------------
module pressure_trend_forecaster_top
    import ptf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic [PRES_W-1:0]        i_pressure,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [SECS_W-1:0]        i_now_seconds,
    input  logic [IDX_W-1:0]         i_entry_index,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TRND_W-1:0] o_trend,
    output logic                     o_trend_found,
    output logic [CODE_W-1:0]        o_forecast_code,
    output logic [PRES_W-1:0]        o_read_pressure,
    output logic signed [TEMP_W-1:0] o_read_temperature,
    output logic [SECS_W-1:0]        o_read_time,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ptf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptf_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pressure         (i_pressure),
        .i_temperature      (i_temperature),
        .i_now_seconds      (i_now_seconds),
        .i_entry_index      (i_entry_index),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_trend            (o_trend),
        .o_trend_found      (o_trend_found),
        .o_forecast_code    (o_forecast_code),
        .o_read_pressure    (o_read_pressure),
        .o_read_temperature (o_read_temperature),
        .o_read_time        (o_read_time)
    );

endmodule
